// ----- hw/rtl/ldd_pkg.sv -----
// ldd_pkg: shared widths, register indexes, reset values, controller states
// and the command/status structs for the light dip detector.
// No dependencies; every other file imports it.
package ldd_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int FRAC_BITS   = 16;
   localparam int AVG_W       = SAMPLE_BITS + FRAC_BITS;
   localparam int CNT_W       = 13;
   localparam int LEVEL_W     = 12;
   localparam int ALPHA_W     = 16;
   localparam int TOTAL_W     = 32;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int PROD_W      = AVG_W + ALPHA_W;

   // register indexes on the csr port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HISTORY_LENGTH = 2'd0,
      CSR_DIP_THRESHOLD  = 2'd1,
      CSR_REARM_MARGIN   = 2'd2,
      CSR_EMA_ALPHA      = 2'd3
   } csr_index_type;

   // register values after reset
   localparam logic [CNT_W-1:0]   HISTORY_LENGTH_RST = 13'd1000;
   localparam logic [LEVEL_W-1:0] DIP_THRESHOLD_RST  = 12'd228;
   localparam logic [LEVEL_W-1:0] REARM_MARGIN_RST   = 12'd68;
   localparam logic [ALPHA_W-1:0] EMA_ALPHA_RST      = 16'd66;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SMP_WRITE,
      ST_SMP_MUL,
      ST_SMP_ACC,
      ST_SCAN_INIT,
      ST_SCAN_RUN,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic latch_req;
      logic smp_write;
      logic smp_mul;
      logic smp_acc;
      logic scan_init;
      logic scan_run;
      logic scan_finish;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic kind;
      logic seeded;
      logic scan_done;
   } ctrl_status_type;

endpackage

// ----- hw/rtl/ldd_ctrl.sv -----
// ldd_ctrl: sequencer for sample updates and dip scans, plus the response
// valid flag. Depends on ldd_pkg; drives ldd_datapath through ctrl_cmd_type.
module ldd_ctrl import ldd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SMP_WRITE;
            end
         end
         ST_SMP_WRITE: begin
            state_in = status.kind ? ST_SCAN_INIT :
                       (status.seeded ? ST_SMP_MUL : ST_RESULT);
         end
         ST_SMP_MUL:   state_in = ST_SMP_ACC;
         ST_SMP_ACC:   state_in = ST_RESULT;
         ST_SCAN_INIT: state_in = ST_SCAN_RUN;
         ST_SCAN_RUN: begin
            if (status.scan_done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands to the datapath
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE:      cmd.latch_req   = req_valid;
         ST_SMP_WRITE: cmd.smp_write   = !status.kind;
         ST_SMP_MUL:   cmd.smp_mul     = 1'b1;
         ST_SMP_ACC:   cmd.smp_acc     = 1'b1;
         ST_SCAN_INIT: cmd.scan_init   = 1'b1;
         ST_SCAN_RUN: begin
            cmd.scan_run    = 1'b1;
            cmd.scan_finish = status.scan_done;
         end
         ST_RESULT:    cmd.load_rsp    = rsp_free;
         default:      cmd = '0;
      endcase
   end

   // hold the word until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- hw/rtl/ldd_datapath.sv -----
// ldd_datapath: config registers, history memory, moving average unit,
// dip scan pipeline and response registers. Depends on ldd_pkg.
module ldd_datapath import ldd_pkg::*; #(
   parameter int HISTORY_DEPTH = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_kind,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  ctrl_cmd_type          cmd,
   output ctrl_status_type       status,
   output logic [CNT_W-1:0]      rsp_dip_count,
   output logic [LEVEL_W-1:0]    rsp_average_level,
   output logic [CNT_W-1:0]      rsp_history_fill,
   output logic [TOTAL_W-1:0]    rsp_total_samples
);

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int DW = $clog2(HISTORY_DEPTH + 1);
   localparam int LW = (DW > CNT_W) ? DW : CNT_W;
   localparam logic [LW-1:0] DEPTH_L = LW'(HISTORY_DEPTH);

   // configuration
   logic [CNT_W-1:0]   hist_len_ff;
   logic [LEVEL_W-1:0] thr_ff;
   logic [LEVEL_W-1:0] margin_ff;
   logic [ALPHA_W-1:0] alpha_ff;

   // latched request
   logic                   kind_ff;
   logic [SAMPLE_BITS-1:0] sample_ff;

   // history and average state
   logic [SAMPLE_BITS-1:0] mem [HISTORY_DEPTH];
   logic [AW-1:0]          wp_ff;
   logic [AW-1:0]          wp_in;
   logic [AW-1:0]          wp_eff;
   logic [LW-1:0]          wp_inc;
   logic [CNT_W-1:0]       fill_ff;
   logic [AVG_W-1:0]       avg_ff;
   logic                   seeded_ff;
   logic [CNT_W-1:0]       last_dip_ff;
   logic [TOTAL_W-1:0]     total_ff;
   logic [CNT_W-1:0]       len;
   logic [AVG_W-1:0]       target;
   logic                   neg_ff;
   logic [AVG_W-1:0]       dmag_ff;
   logic [PROD_W-1:0]      prod_ff;

   // scan pipeline
   logic [AW-1:0]          scan_addr_ff;
   logic [AW-1:0]          scan_addr_in;
   logic [LW-1:0]          scan_addr_inc;
   logic [AW-1:0]          scan_start;
   logic [CNT_W-1:0]       remain_ff;
   logic                   issue;
   logic                   rd_valid_ff;
   logic [SAMPLE_BITS-1:0] rd_data_ff;
   logic                   armed_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [AVG_W:0]         rearm_lvl_ff;
   logic [AVG_W-1:0]       rd_value;
   logic [AVG_W-1:0]       drop;
   logic                   is_dip;
   logic                   is_rearm;

   // effective length: zero acts as one, clamp to the memory depth
   always_comb begin
      if (hist_len_ff == '0) begin
         len = CNT_W'(1);
      end else if (LW'(hist_len_ff) > DEPTH_L) begin
         len = DEPTH_L[CNT_W-1:0];
      end else begin
         len = hist_len_ff;
      end
   end

   // ring write pointer advance
   assign wp_eff = (LW'(wp_ff) >= LW'(len)) ? '0 : wp_ff;
   assign wp_inc = LW'(wp_eff) + LW'(1);
   assign wp_in  = (wp_inc >= LW'(len)) ? '0 : wp_inc[AW-1:0];
   assign target = {sample_ff, {FRAC_BITS{1'b0}}};

   // scan address advance and start point (oldest entry)
   assign issue         = cmd.scan_run && (remain_ff != '0);
   assign scan_addr_inc = LW'(scan_addr_ff) + LW'(1);
   assign scan_addr_in  = (scan_addr_inc >= LW'(len)) ? '0 : scan_addr_inc[AW-1:0];
   assign scan_start    = ((fill_ff < len) || (LW'(wp_ff) >= LW'(len))) ? '0 : wp_ff;

   // dip and rearm tests on the word just read
   assign rd_value = {rd_data_ff, {FRAC_BITS{1'b0}}};
   assign drop     = avg_ff - rd_value;
   assign is_dip   = armed_ff && (avg_ff > rd_value)
                     && (drop >= {thr_ff, {FRAC_BITS{1'b0}}});
   assign is_rearm = !armed_ff && ({1'b0, rd_value} > rearm_lvl_ff);

   assign status.kind      = kind_ff;
   assign status.seeded    = seeded_ff;
   assign status.scan_done = (remain_ff == '0) && !rd_valid_ff;

   // history memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.smp_write) begin
         mem[wp_eff] <= sample_ff;
      end
      if (issue) begin
         rd_data_ff <= mem[scan_addr_ff];
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_len_ff <= HISTORY_LENGTH_RST;
         thr_ff      <= DIP_THRESHOLD_RST;
         margin_ff   <= REARM_MARGIN_RST;
         alpha_ff    <= EMA_ALPHA_RST;
         wp_ff       <= '0;
         fill_ff     <= '0;
         avg_ff      <= '0;
         seeded_ff   <= 1'b0;
         last_dip_ff <= '0;
         total_ff    <= '0;
         remain_ff   <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         // config writes; a new length empties the history
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_HISTORY_LENGTH: begin
                  hist_len_ff <= csr_wdata[CNT_W-1:0];
                  wp_ff       <= '0;
                  fill_ff     <= '0;
               end
               CSR_DIP_THRESHOLD: thr_ff    <= csr_wdata[LEVEL_W-1:0];
               CSR_REARM_MARGIN:  margin_ff <= csr_wdata[LEVEL_W-1:0];
               CSR_EMA_ALPHA:     alpha_ff  <= csr_wdata[ALPHA_W-1:0];
               default: ;
            endcase
         end
         // store sample, seed the average on the first one
         if (cmd.smp_write) begin
            wp_ff <= wp_in;
            if (fill_ff < len) begin
               fill_ff <= fill_ff + CNT_W'(1);
            end
            if (total_ff != '1) begin
               total_ff <= total_ff + TOTAL_W'(1);
            end
            if (!seeded_ff) begin
               avg_ff    <= target;
               seeded_ff <= 1'b1;
            end
         end
         // apply the scaled step toward the sample
         if (cmd.smp_acc) begin
            if (neg_ff) begin
               avg_ff <= avg_ff - prod_ff[PROD_W-1:FRAC_BITS];
            end else begin
               avg_ff <= avg_ff + prod_ff[PROD_W-1:FRAC_BITS];
            end
         end
         // scan bookkeeping
         if (cmd.scan_init) begin
            remain_ff   <= seeded_ff ? fill_ff : '0;
            rd_valid_ff <= 1'b0;
         end else if (cmd.scan_run) begin
            rd_valid_ff <= issue;
            if (issue) begin
               remain_ff <= remain_ff - CNT_W'(1);
            end
         end
         if (cmd.scan_finish) begin
            last_dip_ff <= count_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         kind_ff   <= req_kind;
         sample_ff <= req_sample;
      end
      // difference magnitude and sign
      if (cmd.smp_write) begin
         neg_ff  <= (target < avg_ff);
         dmag_ff <= (target < avg_ff) ? (avg_ff - target) : (target - avg_ff);
      end
      if (cmd.smp_mul) begin
         prod_ff <= PROD_W'(dmag_ff) * PROD_W'(alpha_ff);
      end
      if (cmd.scan_init) begin
         scan_addr_ff <= scan_start;
         armed_ff     <= 1'b1;
         count_ff     <= '0;
         rearm_lvl_ff <= {1'b0, avg_ff} + {1'b0, margin_ff, {FRAC_BITS{1'b0}}};
      end else begin
         if (issue) begin
            scan_addr_ff <= scan_addr_in;
         end
         if (cmd.scan_run && rd_valid_ff) begin
            if (is_dip) begin
               armed_ff <= 1'b0;
               count_ff <= count_ff + CNT_W'(1);
            end else if (is_rearm) begin
               armed_ff <= 1'b1;
            end
         end
      end
      if (cmd.load_rsp) begin
         rsp_dip_count     <= last_dip_ff;
         rsp_average_level <= avg_ff[AVG_W-1:FRAC_BITS];
         rsp_history_fill  <= fill_ff;
         rsp_total_samples <= total_ff;
      end
   end

endmodule

// ----- hw/rtl/light_dip_detector_top.sv -----
// light_dip_detector_top: ldd_ctrl and ldd_datapath joined; uses ldd_pkg.
// Sample word: SMP_WRITE, SMP_MUL (the 28x16 average multiply), SMP_ACC, RESULT;
// the seeding sample skips to RESULT. The next word is taken once back in idle.
// Dip request: SCAN_INIT, SCAN_RUN over the fill, RESULT; one read per sample.
// Synchronous reset; history memory is not cleared, only registers and pointers.
module light_dip_detector_top import ldd_pkg::*; #(
   parameter int HISTORY_DEPTH = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_kind,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CNT_W-1:0]       rsp_dip_count,
   output logic [LEVEL_W-1:0]     rsp_average_level,
   output logic [CNT_W-1:0]       rsp_history_fill,
   output logic [TOTAL_W-1:0]     rsp_total_samples
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   ldd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ldd_datapath #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_kind          (req_kind),
      .req_sample        (req_sample),
      .cmd               (cmd),
      .status            (status),
      .rsp_dip_count     (rsp_dip_count),
      .rsp_average_level (rsp_average_level),
      .rsp_history_fill  (rsp_history_fill),
      .rsp_total_samples (rsp_total_samples)
   );

endmodule

// ----- hw/rtl/ldd_checker.sv -----
// ldd_checker: port-level assertions for light_dip_detector_top, bound below.
// Depends on ldd_pkg.
module ldd_checker import ldd_pkg::*; #(
   parameter int HISTORY_DEPTH = 4096
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [CNT_W-1:0]       rsp_dip_count,
   input logic [LEVEL_W-1:0]     rsp_average_level,
   input logic [CNT_W-1:0]       rsp_history_fill,
   input logic [TOTAL_W-1:0]     rsp_total_samples
);

   localparam int LW = ($clog2(HISTORY_DEPTH + 1) > CNT_W) ?
                       $clog2(HISTORY_DEPTH + 1) : CNT_W;

   // hold a stalled response word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_dip_count) && $stable(rsp_average_level)
         && $stable(rsp_history_fill) && $stable(rsp_total_samples))
      else $error("stalled response word changed");

   // one word at a time: ready drops right after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is in work");

   // fill and dip count of a valid response never exceed the history depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (LW'(rsp_history_fill) <= LW'(HISTORY_DEPTH))
         && (LW'(rsp_dip_count) <= LW'(HISTORY_DEPTH)))
      else $error("history fill or dip count beyond depth");

endmodule

bind light_dip_detector_top ldd_checker #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_ldd_checker (.*);

// ----- tb/light_dip_detector_top_tb.sv -----
// light_dip_detector_top_tb: self-checking bench for the light dip detector top level.
// Keeps its own copy of the average, history ring and dip scan, and compares every report.
// Depends on ldd_pkg and light_dip_detector_top only.
`timescale 1ns / 100ps

module light_dip_detector_top_tb;
   import ldd_pkg::*;

   localparam int  HIST_DEPTH    = 4096;
   localparam int  SETTLE_CYCLES = 8;
   localparam int  QUIET_LIMIT   = 30000;
   localparam bit  KIND_SAMPLE   = 1'b0;
   localparam bit  KIND_SCAN     = 1'b1;

   // one report word as the block returns it
   typedef struct packed {
      logic [CNT_W-1:0]   dips;
      logic [LEVEL_W-1:0] level;
      logic [CNT_W-1:0]   fill;
      logic [TOTAL_W-1:0] total;
   } light_report_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   csr_index_type          csr_index = CSR_HISTORY_LENGTH;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_kind = KIND_SAMPLE;
   logic [SAMPLE_BITS-1:0] req_sample = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [CNT_W-1:0]       rsp_dip_count;
   logic [LEVEL_W-1:0]     rsp_average_level;
   logic [CNT_W-1:0]       rsp_history_fill;
   logic [TOTAL_W-1:0]     rsp_total_samples;

   light_dip_detector_top #(.HISTORY_DEPTH(HIST_DEPTH)) dut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_dip_count     (rsp_dip_count),
      .rsp_average_level (rsp_average_level),
      .rsp_history_fill  (rsp_history_fill),
      .rsp_total_samples (rsp_total_samples)
   );

   always #5 clock = ~clock;

   // predictor state: history ring, average in Q.16, counters
   logic [SAMPLE_BITS-1:0] hist_mem [0:HIST_DEPTH-1];
   int unsigned            wr_pos = 0;
   int unsigned            fill_cnt = 0;
   int unsigned            dips_last = 0;
   longint                 avg_q16 = 0;
   bit                     seeded = 1'b0;
   logic [TOTAL_W-1:0]     total_cnt = '0;

   // predictor copy of the registers
   int len_cfg    = int'(HISTORY_LENGTH_RST);
   int thr_cfg    = int'(DIP_THRESHOLD_RST);
   int margin_cfg = int'(REARM_MARGIN_RST);
   int alpha_cfg  = int'(EMA_ALPHA_RST);

   light_report_type pending_reports [$];
   light_report_type head_report;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int fault_count   = 0;
   int quiet_cycles  = 0;
   int words_sent    = 0;
   int sample_words  = 0;
   int scan_words    = 0;
   int reports_seen  = 0;
   int settings_used = 0;

   function automatic int unsigned kept_length();
      if (len_cfg == 0) return 1;
      if (len_cfg > HIST_DEPTH) return HIST_DEPTH;
      return len_cfg;
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] clamp_level(int v);
      if (v < 0) return '0;
      if (v > 4095) return '1;
      return v[SAMPLE_BITS-1:0];
   endfunction

   // mirror a register write; a new history length empties the ring
   task automatic apply_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_HISTORY_LENGTH: begin
            len_cfg  = int'(value & 16'h1FFF);
            wr_pos   = 0;
            fill_cnt = 0;
         end
         CSR_DIP_THRESHOLD: thr_cfg = int'(value & 16'h0FFF);
         CSR_REARM_MARGIN:  margin_cfg = int'(value & 16'h0FFF);
         CSR_EMA_ALPHA:     alpha_cfg = int'(value);
         default: ;
      endcase
   endtask

   // advance the model by one word and return the report it should produce
   function automatic light_report_type advance_light_model(bit kind,
                                                            logic [SAMPLE_BITS-1:0] smp);
      light_report_type rep;
      int unsigned   len;
      int unsigned   start;
      int unsigned   pos;
      int unsigned   count;
      longint        target;
      longint        d;
      longint        thr;
      longint        rearm;
      longint        v;
      bit            armed;
      len = kept_length();
      if (kind == KIND_SAMPLE) begin
         if (wr_pos >= len) wr_pos = 0;
         hist_mem[wr_pos] = smp;
         wr_pos++;
         if (wr_pos >= len) wr_pos = 0;
         if (fill_cnt < len) fill_cnt++;
         target = longint'(smp) << FRAC_BITS;
         if (!seeded) begin
            avg_q16 = target;
            seeded  = 1'b1;
         end else begin
            d = target - avg_q16;
            if (d >= 0) avg_q16 += (d * alpha_cfg) >>> FRAC_BITS;
            else        avg_q16 -= ((-d) * alpha_cfg) >>> FRAC_BITS;
         end
         if (total_cnt != '1) total_cnt++;
      end else begin
         count = 0;
         if (seeded) begin
            thr   = longint'(thr_cfg) << FRAC_BITS;
            rearm = avg_q16 + (longint'(margin_cfg) << FRAC_BITS);
            armed = 1'b1;
            if (fill_cnt > len) fill_cnt = len;
            start = (fill_cnt < len) ? 0 : wr_pos;
            if (start >= len) start = 0;
            // walk oldest to newest; a counted dip is not tested for rearm
            for (int unsigned i = 0; i < fill_cnt; i++) begin
               pos = (start + i) % len;
               v   = longint'(hist_mem[pos]) << FRAC_BITS;
               if (armed && avg_q16 > v && avg_q16 - v >= thr) begin
                  armed = 1'b0;
                  count++;
               end else if (!armed && v > rearm) begin
                  armed = 1'b1;
               end
            end
         end
         dips_last = count;
      end
      rep.dips  = dips_last[CNT_W-1:0];
      rep.level = LEVEL_W'(avg_q16 >>> FRAC_BITS);
      rep.fill  = fill_cnt[CNT_W-1:0];
      rep.total = total_cnt;
      return rep;
   endfunction

   task automatic check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fault_count++;
      end
   endtask

   // receiver: stall at the current rate, change at the falling edge
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // compare each accepted report with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            $display("%0t ns: unexpected report, expected none, actual dips %0d level %0d",
                     $time, rsp_dip_count, rsp_average_level);
            fault_count++;
         end else begin
            head_report = pending_reports.pop_front();
            check_field("dip_count", head_report.dips, rsp_dip_count);
            check_field("average_level", head_report.level, rsp_average_level);
            check_field("history_fill", head_report.fill, rsp_history_fill);
            check_field("total_samples", head_report.total, rsp_total_samples);
            reports_seen++;
         end
      end
   end

   // watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid === 1'b1 && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
         $display("%0t ns: no word moved for %0d cycles", $time, QUIET_LIMIT);
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // send one word; called and returns at a falling edge
   task automatic send_word(bit kind, logic [SAMPLE_BITS-1:0] smp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_kind   <= kind;
      req_sample <= smp;
      do @(posedge clock); while (!req_ready);
      pending_reports.push_back(advance_light_model(kind, smp));
      words_sent++;
      if (kind == KIND_SAMPLE) sample_words++;
      else scan_words++;
      @(negedge clock);
   endtask

   // hold off the sender until every report is back, then let the block settle
   task automatic drain_reports();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      apply_csr(idx, value);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_settings(int len, int thr, int margin, int alpha);
      drain_reports();
      write_register(CSR_HISTORY_LENGTH, CSR_DATA_W'(len));
      write_register(CSR_DIP_THRESHOLD, CSR_DATA_W'(thr));
      write_register(CSR_REARM_MARGIN, CSR_DATA_W'(margin));
      write_register(CSR_EMA_ALPHA, CSR_DATA_W'(alpha));
      settings_used++;
   endtask

   // samples around the running average with dips and rearm peaks, then a scan
   task automatic send_dip_run();
      int center;
      int lvl;
      int r;
      center = seeded ? int'(avg_q16 >>> FRAC_BITS) : int'($urandom_range(400, 3600));
      repeat ($urandom_range(3, 24)) begin
         r = $urandom_range(99);
         if (r < 15) lvl = center - thr_cfg - int'($urandom_range(0, 40));
         else if (r < 30) lvl = center + margin_cfg + int'($urandom_range(1, 40));
         else lvl = center + int'($urandom_range(0, 60)) - 30;
         send_word(KIND_SAMPLE, clamp_level(lvl));
         if ($urandom_range(1) == 0) center = int'(avg_q16 >>> FRAC_BITS);
      end
      send_word(KIND_SCAN, SAMPLE_BITS'($urandom));
   endtask

   // unstructured words over the full sample range
   task automatic send_noise();
      repeat ($urandom_range(1, 8)) begin
         send_word(($urandom_range(9) < 3) ? KIND_SCAN : KIND_SAMPLE, SAMPLE_BITS'($urandom));
      end
   endtask

   // scan before any sample: nothing seeded, no dips; sample field ignored
   task automatic test_unseeded_scan();
      send_word(KIND_SCAN, '1);
      send_word(KIND_SCAN, '0);
   endtask

   // full-range samples with the fastest average and no threshold or margin
   task automatic test_fast_average();
      write_settings(4, 0, 0, 65535);
      send_word(KIND_SAMPLE, '1);
      send_word(KIND_SAMPLE, '0);
      send_word(KIND_SAMPLE, '1);
      send_word(KIND_SAMPLE, '0);
      send_word(KIND_SAMPLE, '1);
      send_word(KIND_SCAN, '0);
   endtask

   // widest threshold and margin with the slowest average
   task automatic test_wide_thresholds();
      write_settings(6, 4095, 4095, 1);
      send_word(KIND_SAMPLE, '0);
      send_word(KIND_SAMPLE, '0);
      send_word(KIND_SAMPLE, '1);
      send_word(KIND_SCAN, '1);
   endtask

   // zero weight: the average stays where it was
   task automatic test_frozen_average();
      write_settings(3, 100, 10, 0);
      send_word(KIND_SAMPLE, 12'd100);
      send_word(KIND_SAMPLE, 12'd3000);
      send_word(KIND_SCAN, '0);
   endtask

   // zero and one length, then a length write that empties the ring
   task automatic test_length_edges();
      write_settings(0, 10, 5, 66);
      send_word(KIND_SAMPLE, 12'd7);
      send_word(KIND_SAMPLE, 12'd9);
      send_word(KIND_SCAN, '0);
      write_settings(1, 10, 5, 66);
      send_word(KIND_SAMPLE, 12'd11);
      send_word(KIND_SCAN, '0);
      drain_reports();
      write_register(CSR_HISTORY_LENGTH, CSR_DATA_W'(8));
      send_word(KIND_SCAN, '0);
   endtask

   // random settings and traffic under one idling mix
   task automatic test_random_phase(int idle, int stall, int goal, int rounds);
      int stop_at;
      int len;
      int thr;
      int margin;
      int alpha;
      send_idle_pct = idle;
      stall_pct     = stall;
      repeat (rounds) begin
         len    = ($urandom_range(9) < 7) ? $urandom_range(1, 32) : $urandom_range(33, 300);
         thr    = ($urandom_range(9) < 8) ? $urandom_range(0, 300) : $urandom_range(0, 4095);
         margin = ($urandom_range(9) < 8) ? $urandom_range(0, 200) : $urandom_range(0, 4095);
         case ($urandom_range(4))
            0:       alpha = 1;
            1:       alpha = $urandom_range(1, 1023);
            2:       alpha = $urandom_range(1024, 32767);
            3:       alpha = 65535;
            default: alpha = $urandom_range(1, 65535);
         endcase
         write_settings(len, thr, margin, alpha);
         stop_at = words_sent + goal / rounds;
         while (words_sent < stop_at) begin
            if ($urandom_range(99) < 85) send_dip_run();
            else send_noise();
         end
      end
   endtask

   // length above the depth acts as the full depth
   task automatic test_deep_history();
      int stop_at;
      send_idle_pct = 0;
      stall_pct     = 0;
      write_settings(13'h1FFF, 150, 40, 2048);
      stop_at = words_sent + 200;
      while (words_sent < stop_at) send_dip_run();
      drain_reports();
      write_register(CSR_HISTORY_LENGTH, CSR_DATA_W'(HIST_DEPTH));
      repeat (6) send_dip_run();
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_unseeded_scan();
      test_fast_average();
      test_wide_thresholds();
      test_frozen_average();
      test_length_edges();
      test_random_phase(0, 0, 280, 3);
      test_random_phase(83, 0, 280, 3);
      test_random_phase(0, 83, 280, 3);
      test_random_phase(19, 19, 280, 3);
      test_deep_history();
      drain_reports();
      repeat (16) @(negedge clock);
      $display("Summary: %0d sample words and %0d dip scans over %0d register settings",
               sample_words, scan_words, settings_used);
      $display("Summary: %0d reports compared across four idling mixes and a full-depth ring",
               reports_seen);
      if (fault_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- light_dip_detector_top.f -----
hw/rtl/ldd_pkg.sv
hw/rtl/ldd_ctrl.sv
hw/rtl/ldd_datapath.sv
hw/rtl/light_dip_detector_top.sv
hw/rtl/ldd_checker.sv
tb/light_dip_detector_top_tb.sv
